>>> sv/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, sizes and codes of the indexed list stack.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int DEPTH   = 16;
	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int CNT_W   = 5;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// commands
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

	// result status
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	// per-cycle cell operation
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_DEL  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	typedef struct packed {
		logic [1:0]       mode;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> sv/ils_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_req_if / ils_rsp_if
// Valid/ready channels for commands and results of the indexed list stack.
// ----------------------------------------------------------------------------
interface ils_req_if import ils_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, output command, output position, output item_value,
		input ready);
	modport sink (input valid, input command, input position, input item_value,
		output ready);
endinterface

interface ils_rsp_if import ils_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         entry_count;
	logic                     last_of_run;

	modport source (output valid, output read_value, output status, output entry_count,
		output last_of_run, input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		input last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/ils_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell
// One list entry; holds, loads, or takes the value of a neighbor each cycle.
// ----------------------------------------------------------------------------
module ils_cell import ils_pkg::*; (
	input  wire logic                     clk,
	input  wire cell_ctl_t                ctl,
	input  wire logic [IDX_W-1:0]         idx,
	input  wire logic signed [DATA_W-1:0] prev_value,
	input  wire logic signed [DATA_W-1:0] next_value,
	input  wire logic signed [DATA_W-1:0] load_value,
	output logic signed [DATA_W-1:0]      value
);

	logic [POS_W-1:0]         my_pos;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] value_d;

	assign my_pos = POS_W'(idx);

	always_comb begin
		value_d = value_q;
		case (ctl.mode)
			CELL_INS: begin
				if (my_pos == ctl.pos) begin
					value_d = load_value;
				end else if (my_pos > ctl.pos) begin
					value_d = prev_value;
				end
			end
			CELL_DEL: begin
				if (my_pos >= ctl.pos) begin
					value_d = next_value;
				end
			end
			// rotate the first pos+1 entries up by one, old top goes to pos
			CELL_ROT: begin
				if (my_pos == ctl.pos) begin
					value_d = load_value;
				end else if (my_pos < ctl.pos) begin
					value_d = next_value;
				end
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule
`default_nettype wire

>>> sv/indexed_list_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_stack
// Ordered list of signed 32-bit values with stack, indexed and dump commands.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH entry cells, index 0 being the stack top.
// For push, pop, top, insert and delete every cell picks its own value, its
// neighbor's, or the new value, so insert and delete shift the whole row at
// once. One command is taken per cycle as long as the result register is free
// or being drained. A dump answers with one result per stored entry, one per
// cycle while the result register is free or being drained, by rotating the
// row up so the top cell always holds the next entry; after the last result
// the list is back in order. Commands are not taken while a dump is running.
// Codes six and seven are swallowed without a result.
module indexed_list_stack import ils_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ils_req_if.sink   req,
	ils_rsp_if.source rsp
);

	cell_ctl_t                cell_ctl;
	logic signed [DATA_W-1:0] load_value;
	logic signed [DATA_W-1:0] cell_value [DEPTH];
	logic signed [DATA_W-1:0] top_value;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     dump_q;
	logic [CNT_W-1:0]         dump_left_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [STAT_W-1:0]        status_q;
	logic [CNT_W-1:0]         entry_count_q;
	logic                     last_q;

	logic                     load_ok;
	logic                     accept;
	logic                     emit;
	logic                     dump_start;
	logic signed [DATA_W-1:0] r_value;
	logic [STAT_W-1:0]        r_status;
	logic                     r_last;

	assign load_ok   = !out_valid_q || rsp.ready;
	assign req.ready = !dump_q && load_ok;
	assign accept    = req.valid && req.ready;
	assign top_value = cell_value[0];

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_v;
		logic signed [DATA_W-1:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = load_value;
		end else begin : g_mid_p
			assign prev_v = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_v = cell_value[i];
		end else begin : g_mid_n
			assign next_v = cell_value[i+1];
		end
		ils_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.idx        (IDX_W'(i)),
			.prev_value (prev_v),
			.next_value (next_v),
			.load_value (load_value),
			.value      (cell_value[i])
		);
	end

	always_comb begin
		cell_ctl   = '{mode: CELL_HOLD, pos: '0};
		load_value = req.item_value;
		count_d    = count_q;
		emit       = 1'b0;
		dump_start = 1'b0;
		r_value    = '0;
		r_status   = ST_OK;
		r_last     = 1'b1;
		if (dump_q) begin
			if (load_ok) begin
				emit       = 1'b1;
				r_value    = top_value;
				r_last     = (dump_left_q == CNT_W'(1));
				cell_ctl   = '{mode: CELL_ROT, pos: POS_W'(count_q - CNT_W'(1))};
				load_value = top_value;
			end
		end else if (accept) begin
			case (req.command)
				CMD_PUSH: begin
					emit = 1'b1;
					if (count_q >= FULL_COUNT) begin
						r_status = ST_FULL;
					end else begin
						cell_ctl = '{mode: CELL_INS, pos: '0};
						count_d  = count_q + CNT_W'(1);
					end
				end
				CMD_POP: begin
					emit = 1'b1;
					if (count_q == '0) begin
						r_status = ST_EMPTY;
						r_value  = -32'sd1;
					end else begin
						cell_ctl = '{mode: CELL_DEL, pos: '0};
						count_d  = count_q - CNT_W'(1);
					end
				end
				CMD_TOP: begin
					emit = 1'b1;
					if (count_q == '0) begin
						r_status = ST_EMPTY;
						r_value  = -32'sd1;
					end else begin
						r_value = top_value;
					end
				end
				CMD_INSERT: begin
					emit = 1'b1;
					if (req.position > POS_W'(count_q)) begin
						r_status = ST_BAD_IDX;
					end else if (count_q >= FULL_COUNT) begin
						r_status = ST_FULL;
					end else begin
						cell_ctl = '{mode: CELL_INS, pos: req.position};
						count_d  = count_q + CNT_W'(1);
					end
				end
				CMD_DELETE: begin
					emit = 1'b1;
					if (req.position >= POS_W'(count_q)) begin
						r_status = ST_BAD_IDX;
					end else begin
						cell_ctl = '{mode: CELL_DEL, pos: req.position};
						count_d  = count_q - CNT_W'(1);
					end
				end
				CMD_DUMP: begin
					emit = 1'b1;
					if (count_q == '0) begin
						r_status = ST_EMPTY;
						r_value  = -32'sd1;
					end else begin
						r_value    = top_value;
						r_last     = (count_q == CNT_W'(1));
						cell_ctl   = '{mode: CELL_ROT, pos: POS_W'(count_q - CNT_W'(1))};
						load_value = top_value;
						dump_start = (count_q != CNT_W'(1));
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_q      <= 1'b0;
			dump_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (dump_start) begin
				dump_q      <= 1'b1;
				dump_left_q <= count_q - CNT_W'(1);
			end else if (dump_q && load_ok) begin
				dump_left_q <= dump_left_q - CNT_W'(1);
				if (dump_left_q == CNT_W'(1)) begin
					dump_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			read_value_q  <= r_value;
			status_q      <= r_status;
			entry_count_q <= count_d;
			last_q        <= r_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.last_of_run = last_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count beyond depth");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> (count_q != '0) && (dump_left_q != '0))
		else $error("dump running with nothing left");

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> !req.ready)
		else $error("request taken during dump");

	a_request_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command <= CMD_DUMP) |=> out_valid_q)
		else $error("request produced no result");

	a_dump_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_q && $past(dump_q)) |-> $stable(count_q))
		else $error("count changed during dump");
`endif

endmodule
`default_nettype wire
